>>> rtl/lspd_pkg.sv
// Shared types, constants and the phi table of the LDPC sum-product decoder.
`default_nettype none

package lspd_pkg;

  localparam int VAR_IDX_W = 10;
  localparam int CHK_IDX_W = 9;
  localparam int LLR_IN_W  = 8;
  localparam int POST_W    = 12;
  localparam int ITER_W    = 7;
  localparam int ITER_CAP  = 64;

  localparam int DEF_MAX_VARS   = 1024;
  localparam int DEF_MAX_CHECKS = 512;
  localparam int DEF_MAX_EDGES  = 4096;
  localparam int DEF_LLR_WIDTH  = 8;

  localparam logic [10:0] RST_NUM_VARS   = 11'd1024;
  localparam logic [9:0]  RST_NUM_CHECKS = 10'd512;
  localparam logic [6:0]  RST_MAX_ITER   = 7'd20;

  localparam logic [1:0] REG_NUM_VARS   = 2'd0;
  localparam logic [1:0] REG_NUM_CHECKS = 2'd1;
  localparam logic [1:0] REG_MAX_ITER   = 2'd2;

  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_BIT    = 1'b1;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_LOAD   = 3'd1,
    OP_DECODE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_HCLR,
    ST_IDLE,
    ST_RD,
    ST_OUT,
    ST_DUPI,
    ST_DUPL,
    ST_DUPJ,
    ST_DUPW,
    ST_EDGE,
    ST_CLR,
    ST_NODE
  } state_t;

  typedef enum logic [2:0] {
    PASS_INIT,
    PASS_CHK,
    PASS_C2V,
    PASS_V2C,
    PASS_SYN,
    PASS_POST,
    PASS_SCAN
  } pass_t;

  typedef struct packed {
    logic [10:0] num_vars;
    logic [9:0]  num_checks;
    logic [6:0]  max_iter;
  } cfg_t;

  typedef struct packed {
    op_t                        op;
    logic [VAR_IDX_W-1:0]       var_index;
    logic [CHK_IDX_W-1:0]       check_index;
    logic signed [LLR_IN_W-1:0] channel_llr;
  } item_t;

  typedef struct packed {
    logic                     result_kind;
    logic                     parity_ok;
    logic [ITER_W-1:0]        iterations_used;
    logic                     hard_bit;
    logic signed [POST_W-1:0] posterior_llr;
  } result_t;

  // round(4 * -ln(tanh(s/8))), zero beyond the table
  function automatic logic [6:0] phi_lut(input logic [3:0] s);
    logic [6:0] r;
    case (s)
      4'd0:    r = 7'd127;
      4'd1:    r = 7'd8;
      4'd2:    r = 7'd6;
      4'd3:    r = 7'd4;
      4'd4:    r = 7'd3;
      4'd5:    r = 7'd2;
      4'd6:    r = 7'd2;
      4'd7:    r = 7'd1;
      4'd8:    r = 7'd1;
      4'd9:    r = 7'd1;
      4'd10:   r = 7'd1;
      4'd11:   r = 7'd1;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lspd_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module lspd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/lspd_core.sv
// Decoder sequencer: edge and node memories and the message-passing datapath.
`default_nettype none

module lspd_core #(
  parameter int MAX_VARS   = lspd_pkg::DEF_MAX_VARS,
  parameter int MAX_CHECKS = lspd_pkg::DEF_MAX_CHECKS,
  parameter int MAX_EDGES  = lspd_pkg::DEF_MAX_EDGES,
  parameter int LLR_WIDTH  = lspd_pkg::DEF_LLR_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lspd_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lspd_pkg::item_t   item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lspd_pkg::result_t      res
);

  localparam int VW     = $clog2(MAX_VARS);
  localparam int CW     = $clog2(MAX_CHECKS);
  localparam int EW     = $clog2(MAX_EDGES);
  localparam int VCW    = $clog2(MAX_VARS + 1);
  localparam int CCW    = $clog2(MAX_CHECKS + 1);
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam int NW     = (VCW > CCW) ? VCW : CCW;
  localparam int LW     = LLR_WIDTH;
  localparam int TPHI_W = EW + 8;
  localparam int TOT_W  = EW + LW + 2;
  localparam int SUM_W  = (EW + LW + 3 > 13) ? EW + LW + 3 : 13;
  localparam int EDW    = lspd_pkg::VAR_IDX_W + lspd_pkg::CHK_IDX_W;
  localparam int MSG_MAX = (1 << (LW - 1)) - 1;
  localparam logic signed [SUM_W-1:0] SMSG_MAX  = SUM_W'(MSG_MAX);
  localparam logic signed [SUM_W-1:0] SMSG_MIN  = -SMSG_MAX - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SPOST_MAX = SUM_W'(2047);
  localparam logic signed [SUM_W-1:0] SPOST_MIN = -SPOST_MAX - SUM_W'(1);

  lspd_pkg::state_t  state_r, state_nxt;
  lspd_pkg::pass_t   pass_r, pass_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [ECW-1:0]    e_r, e_nxt;
  logic [ECW-1:0]    j_r, j_nxt;
  logic [ECW-1:0]    cnt_r, cnt_nxt;
  logic [ECW-1:0]    dcnt_r, dcnt_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic              dirty_r, dirty_nxt;
  logic              pv_r, pv_nxt;
  logic              fail_r, fail_nxt;
  logic              ok_r, ok_nxt;
  logic [6:0]        it_r, it_nxt;
  logic [lspd_pkg::VAR_IDX_W-1:0] hv_r, hv_nxt, rdv_r, rdv_nxt;
  logic [lspd_pkg::CHK_IDX_W-1:0] hc_r, hc_nxt;
  logic              out_valid_r, out_valid_nxt;
  lspd_pkg::result_t res_r, res_nxt;

  // effective configuration
  logic [VCW-1:0] nv_eff;
  logic [CCW-1:0] nc_eff;
  logic [NW-1:0]  n_max;
  logic [6:0]     lim;

  assign nv_eff = (32'(cfg.num_vars) > MAX_VARS) ? VCW'(MAX_VARS) : VCW'(cfg.num_vars);
  assign nc_eff = (32'(cfg.num_checks) > MAX_CHECKS) ? CCW'(MAX_CHECKS)
                                                      : CCW'(cfg.num_checks);
  assign lim    = (cfg.max_iter > 7'(lspd_pkg::ITER_CAP)) ? 7'(lspd_pkg::ITER_CAP)
                                                          : cfg.max_iter;
  assign n_max  = (NW'(nv_eff) > NW'(nc_eff)) ? NW'(nv_eff) : NW'(nc_eff);

  // memory ports
  logic [EDW-1:0]    edge_rd;
  logic [EW-1:0]     edge_ra;
  logic              edge_we;
  logic [ECW-1:0]    dup_rd;
  logic              dup_we;
  logic signed [LW-1:0] v2c_rd, c2v_rd, v2c_wd, c2v_wd;
  logic              v2c_we, c2v_we;
  logic signed [lspd_pkg::LLR_IN_W-1:0] rx_rd;
  logic              rx_we;
  logic signed [TOT_W-1:0] tot_rd, tot_wd;
  logic              tot_we;
  logic [lspd_pkg::POST_W-1:0] post_rd, post_wd;
  logic              post_we;
  logic              hard_rd, hard_wd, hard_we;
  logic [TPHI_W-1:0] tphi_rd, tphi_wd;
  logic              tphi_we;
  logic              tneg_rd, tneg_wd;
  logic              par_rd, par_wd, par_we;
  logic [VW-1:0]     var_ra;
  logic [CW-1:0]     chk_ra;

  logic [lspd_pkg::VAR_IDX_W-1:0] edge_v;
  logic [lspd_pkg::CHK_IDX_W-1:0] edge_c;
  logic edge_act;

  assign edge_v   = edge_rd[EDW-1:lspd_pkg::CHK_IDX_W];
  assign edge_c   = edge_rd[lspd_pkg::CHK_IDX_W-1:0];
  assign edge_act = (32'(edge_v) < 32'(nv_eff)) && (32'(edge_c) < 32'(nc_eff));
  assign edge_ra  = (state_r == lspd_pkg::ST_DUPJ) ? j_r[EW-1:0] : e_r[EW-1:0];

  always_comb begin
    case (state_r)
      lspd_pkg::ST_NODE, lspd_pkg::ST_CLR, lspd_pkg::ST_HCLR: var_ra = VW'(n_r);
      lspd_pkg::ST_RD:                                        var_ra = VW'(rdv_r);
      default:                                                var_ra = VW'(edge_v);
    endcase
    case (state_r)
      lspd_pkg::ST_NODE, lspd_pkg::ST_CLR: chk_ra = CW'(n_r);
      default:                             chk_ra = CW'(edge_c);
    endcase
  end

  lspd_ram #(.W(EDW), .D(MAX_EDGES)) u_edge (
    .clk(clk), .we(edge_we), .waddr(cnt_r[EW-1:0]),
    .wdata({item.var_index, item.check_index}), .raddr(edge_ra), .rdata(edge_rd)
  );
  lspd_ram #(.W(ECW), .D(MAX_EDGES)) u_dup (
    .clk(clk), .we(dup_we), .waddr(e_r[EW-1:0]), .wdata(dcnt_r),
    .raddr(e_r[EW-1:0]), .rdata(dup_rd)
  );
  lspd_ram #(.W(LW), .D(MAX_EDGES)) u_v2c (
    .clk(clk), .we(v2c_we), .waddr(e_r[EW-1:0]), .wdata(v2c_wd),
    .raddr(e_r[EW-1:0]), .rdata(v2c_rd)
  );
  lspd_ram #(.W(LW), .D(MAX_EDGES)) u_c2v (
    .clk(clk), .we(c2v_we), .waddr(e_r[EW-1:0]), .wdata(c2v_wd),
    .raddr(e_r[EW-1:0]), .rdata(c2v_rd)
  );
  lspd_ram #(.W(lspd_pkg::LLR_IN_W), .D(MAX_VARS)) u_rx (
    .clk(clk), .we(rx_we), .waddr(VW'(item.var_index)), .wdata(item.channel_llr),
    .raddr(var_ra), .rdata(rx_rd)
  );
  lspd_ram #(.W(TOT_W), .D(MAX_VARS)) u_tot (
    .clk(clk), .we(tot_we), .waddr(var_ra), .wdata(tot_wd),
    .raddr(var_ra), .rdata(tot_rd)
  );
  lspd_ram #(.W(lspd_pkg::POST_W), .D(MAX_VARS)) u_post (
    .clk(clk), .we(post_we), .waddr(var_ra), .wdata(post_wd),
    .raddr(var_ra), .rdata(post_rd)
  );
  lspd_ram #(.W(1), .D(MAX_VARS)) u_hard (
    .clk(clk), .we(hard_we), .waddr(var_ra), .wdata(hard_wd),
    .raddr(var_ra), .rdata(hard_rd)
  );
  lspd_ram #(.W(TPHI_W), .D(MAX_CHECKS)) u_tphi (
    .clk(clk), .we(tphi_we), .waddr(chk_ra), .wdata(tphi_wd),
    .raddr(chk_ra), .rdata(tphi_rd)
  );
  lspd_ram #(.W(1), .D(MAX_CHECKS)) u_tneg (
    .clk(clk), .we(tphi_we), .waddr(chk_ra), .wdata(tneg_wd),
    .raddr(chk_ra), .rdata(tneg_rd)
  );
  lspd_ram #(.W(1), .D(MAX_CHECKS)) u_par (
    .clk(clk), .we(par_we), .waddr(chk_ra), .wdata(par_wd),
    .raddr(chk_ra), .rdata(par_rd)
  );

  // datapath
  logic [LW-1:0]     mabs;
  logic [6:0]        p_sel, r_phi;
  logic [TPHI_W-1:0] accp, diff;
  logic [LW-1:0]     rmag;
  logic              c_neg;
  logic signed [LW-1:0]    c2v_new;
  logic signed [TOT_W-1:0] accs;
  logic signed [SUM_W-1:0] vsum, psum;
  logic signed [LW-1:0]    v2c_new;
  logic signed [lspd_pkg::POST_W-1:0] post_new;

  always_comb begin
    mabs  = v2c_rd[LW-1] ? LW'(-v2c_rd) : LW'(v2c_rd);
    p_sel = (32'(mabs) < 12) ? lspd_pkg::phi_lut(mabs[3:0]) : 7'd0;
    // duplicated edges carry equal messages, so the own share is count * phi
    accp  = TPHI_W'(dup_rd) * TPHI_W'(p_sel);
    diff  = tphi_rd - accp;
    r_phi = (32'(diff) < 12) ? lspd_pkg::phi_lut(diff[3:0]) : 7'd0;
    rmag  = (32'(r_phi) > MSG_MAX) ? LW'(MSG_MAX) : LW'(r_phi);
    c_neg = tneg_rd ^ (dup_rd[0] & v2c_rd[LW-1]);
    c2v_new = c_neg ? $signed(LW'(0) - rmag) : $signed(rmag);

    accs = TOT_W'($signed({1'b0, dup_rd})) * TOT_W'(c2v_rd);
    if (pass_r == lspd_pkg::PASS_INIT) begin
      vsum = SUM_W'(rx_rd);
    end else begin
      vsum = SUM_W'(rx_rd) + SUM_W'(tot_rd) - SUM_W'(accs);
    end
    if (vsum > SMSG_MAX) begin
      v2c_new = LW'(SMSG_MAX);
    end else if (vsum < SMSG_MIN) begin
      v2c_new = LW'(SMSG_MIN);
    end else begin
      v2c_new = LW'(vsum);
    end

    psum = SUM_W'(rx_rd) + SUM_W'(tot_rd);
    if (psum > SPOST_MAX) begin
      post_new = lspd_pkg::POST_W'(SPOST_MAX);
    end else if (psum < SPOST_MIN) begin
      post_new = lspd_pkg::POST_W'(SPOST_MIN);
    end else begin
      post_new = lspd_pkg::POST_W'(psum);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    ph_nxt        = ph_r;
    e_nxt         = e_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    dcnt_nxt      = dcnt_r;
    n_nxt         = n_r;
    dirty_nxt     = dirty_r;
    pv_nxt        = pv_r;
    fail_nxt      = fail_r;
    ok_nxt        = ok_r;
    it_nxt        = it_r;
    hv_nxt        = hv_r;
    hc_nxt        = hc_r;
    rdv_nxt       = rdv_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    edge_we = 1'b0;
    dup_we  = 1'b0;
    v2c_we  = 1'b0;
    c2v_we  = 1'b0;
    rx_we   = 1'b0;
    tot_we  = 1'b0;
    post_we = 1'b0;
    hard_we = 1'b0;
    tphi_we = 1'b0;
    par_we  = 1'b0;
    v2c_wd  = v2c_new;
    c2v_wd  = c2v_new;
    tot_wd  = '0;
    post_wd = post_new;
    hard_wd = 1'b0;
    tphi_wd = '0;
    tneg_wd = 1'b0;
    par_wd  = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lspd_pkg::ST_HCLR: begin
        hard_we = 1'b1;
        n_nxt   = n_r + NW'(1);
        if (n_r == NW'(MAX_VARS - 1)) begin
          n_nxt     = '0;
          state_nxt = lspd_pkg::ST_IDLE;
        end
      end
      lspd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (item.op)
            lspd_pkg::OP_APPEND: begin
              if (cnt_r != ECW'(MAX_EDGES)) begin
                edge_we   = 1'b1;
                cnt_nxt   = cnt_r + ECW'(1);
                dirty_nxt = 1'b1;
              end
            end
            lspd_pkg::OP_LOAD: begin
              rx_we = (32'(item.var_index) < MAX_VARS);
            end
            lspd_pkg::OP_DECODE: begin
              it_nxt = '0;
              e_nxt  = '0;
              ph_nxt = '0;
              if (lim == 7'd0) begin
                ok_nxt    = 1'b0;
                state_nxt = lspd_pkg::ST_OUT;
              end else if (dirty_r) begin
                state_nxt = lspd_pkg::ST_DUPI;
              end else begin
                pass_nxt  = lspd_pkg::PASS_INIT;
                state_nxt = lspd_pkg::ST_EDGE;
              end
            end
            lspd_pkg::OP_READ: begin
              rdv_nxt   = item.var_index;
              ph_nxt    = '0;
              state_nxt = lspd_pkg::ST_RD;
            end
            lspd_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              dirty_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      lspd_pkg::ST_RD: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (!out_valid_r || out_ready) begin
          res_nxt = '0;
          res_nxt.result_kind = lspd_pkg::RK_BIT;
          if (32'(rdv_r) < MAX_VARS) begin
            res_nxt.hard_bit      = hard_rd;
            res_nxt.posterior_llr = post_rd;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = lspd_pkg::ST_IDLE;
        end
      end
      lspd_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          res_nxt = '0;
          res_nxt.result_kind     = lspd_pkg::RK_STATUS;
          res_nxt.parity_ok       = ok_r;
          res_nxt.iterations_used = it_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lspd_pkg::ST_IDLE;
        end
      end
      // duplicate count per edge, redone only after the edge list changes
      lspd_pkg::ST_DUPI: begin
        if (e_r == cnt_r) begin
          dirty_nxt = 1'b0;
          e_nxt     = '0;
          ph_nxt    = '0;
          pass_nxt  = lspd_pkg::PASS_INIT;
          state_nxt = lspd_pkg::ST_EDGE;
        end else begin
          state_nxt = lspd_pkg::ST_DUPL;
        end
      end
      lspd_pkg::ST_DUPL: begin
        hv_nxt    = edge_v;
        hc_nxt    = edge_c;
        j_nxt     = '0;
        pv_nxt    = 1'b0;
        dcnt_nxt  = '0;
        state_nxt = lspd_pkg::ST_DUPJ;
      end
      lspd_pkg::ST_DUPJ: begin
        if (pv_r && edge_v == hv_r && edge_c == hc_r) begin
          dcnt_nxt = dcnt_r + ECW'(1);
        end
        if (j_r != cnt_r) begin
          j_nxt  = j_r + ECW'(1);
          pv_nxt = 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = lspd_pkg::ST_DUPW;
          end
        end
      end
      lspd_pkg::ST_DUPW: begin
        dup_we    = 1'b1;
        e_nxt     = e_r + ECW'(1);
        state_nxt = lspd_pkg::ST_DUPI;
      end
      lspd_pkg::ST_EDGE: begin
        case (ph_r)
          2'd0: begin
            if (e_r == cnt_r) begin
              e_nxt = '0;
              n_nxt = '0;
              case (pass_r)
                lspd_pkg::PASS_INIT: state_nxt = lspd_pkg::ST_CLR;
                lspd_pkg::PASS_CHK:  pass_nxt  = lspd_pkg::PASS_C2V;
                lspd_pkg::PASS_C2V:  pass_nxt  = lspd_pkg::PASS_V2C;
                lspd_pkg::PASS_V2C: begin
                  pass_nxt  = lspd_pkg::PASS_POST;
                  state_nxt = lspd_pkg::ST_NODE;
                end
                default: begin
                  fail_nxt  = 1'b0;
                  pass_nxt  = lspd_pkg::PASS_SCAN;
                  state_nxt = lspd_pkg::ST_NODE;
                end
              endcase
            end else begin
              ph_nxt = 2'd1;
            end
          end
          2'd1: begin
            if (edge_act) begin
              ph_nxt = 2'd2;
            end else begin
              e_nxt  = e_r + ECW'(1);
              ph_nxt = 2'd0;
            end
          end
          default: begin
            case (pass_r)
              lspd_pkg::PASS_INIT, lspd_pkg::PASS_V2C: v2c_we = 1'b1;
              lspd_pkg::PASS_CHK: begin
                tphi_we = 1'b1;
                tphi_wd = tphi_rd + TPHI_W'(p_sel);
                tneg_wd = tneg_rd ^ v2c_rd[LW-1];
              end
              lspd_pkg::PASS_C2V: begin
                c2v_we = 1'b1;
                tot_we = 1'b1;
                tot_wd = tot_rd + TOT_W'(c2v_new);
              end
              default: begin
                par_we = 1'b1;
                par_wd = par_rd ^ hard_rd;
              end
            endcase
            e_nxt  = e_r + ECW'(1);
            ph_nxt = 2'd0;
          end
        endcase
      end
      lspd_pkg::ST_CLR: begin
        if (n_r == n_max) begin
          e_nxt     = '0;
          ph_nxt    = '0;
          pass_nxt  = lspd_pkg::PASS_CHK;
          state_nxt = lspd_pkg::ST_EDGE;
        end else begin
          tot_we  = (32'(n_r) < 32'(nv_eff));
          tphi_we = (32'(n_r) < 32'(nc_eff));
          par_we  = (32'(n_r) < 32'(nc_eff));
          n_nxt   = n_r + NW'(1);
        end
      end
      lspd_pkg::ST_NODE: begin
        if (ph_r == 2'd0) begin
          if ((pass_r == lspd_pkg::PASS_POST && n_r == NW'(nv_eff)) ||
              (pass_r != lspd_pkg::PASS_POST && n_r == NW'(nc_eff))) begin
            e_nxt = '0;
            if (pass_r == lspd_pkg::PASS_POST) begin
              pass_nxt  = lspd_pkg::PASS_SYN;
              state_nxt = lspd_pkg::ST_EDGE;
            end else begin
              it_nxt = it_r + 7'd1;
              if (!fail_r || (it_r + 7'd1) == lim) begin
                ok_nxt    = !fail_r;
                state_nxt = lspd_pkg::ST_OUT;
              end else begin
                pass_nxt  = lspd_pkg::PASS_CHK;
                state_nxt = lspd_pkg::ST_EDGE;
              end
            end
          end else begin
            ph_nxt = 2'd1;
          end
        end else begin
          if (pass_r == lspd_pkg::PASS_POST) begin
            // totals are cleared here for the next iteration
            post_we = 1'b1;
            hard_we = 1'b1;
            hard_wd = post_new[lspd_pkg::POST_W-1] || (post_new == '0);
            tot_we  = 1'b1;
          end else begin
            if (par_rd) begin
              fail_nxt = 1'b1;
            end
            par_we  = 1'b1;
            tphi_we = 1'b1;
          end
          n_nxt  = n_r + NW'(1);
          ph_nxt = 2'd0;
        end
      end
      default: state_nxt = lspd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lspd_pkg::ST_HCLR;
      pass_r      <= lspd_pkg::PASS_INIT;
      ph_r        <= '0;
      e_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      n_r         <= '0;
      dirty_r     <= 1'b0;
      pv_r        <= 1'b0;
      fail_r      <= 1'b0;
      ok_r        <= 1'b0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      ph_r        <= ph_nxt;
      e_r         <= e_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      dcnt_r      <= dcnt_nxt;
      n_r         <= n_nxt;
      dirty_r     <= dirty_nxt;
      pv_r        <= pv_nxt;
      fail_r      <= fail_nxt;
      ok_r        <= ok_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hv_r  <= hv_nxt;
    hc_r  <= hc_nxt;
    rdv_r <= rdv_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  a_write_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lspd_pkg::ST_EDGE && ph_r == 2'd2) |-> edge_act)
    else $error("edge update on an inactive edge");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lspd_pkg::ST_NODE) |-> (it_r < lim))
    else $error("iteration count beyond limit");

  a_dup_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lspd_pkg::ST_DUPJ && pv_r) |-> (dcnt_r < j_r))
    else $error("duplicate count ahead of scan");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == lspd_pkg::ST_RD ||
                            $past(state_r) == lspd_pkg::ST_OUT))
    else $error("result raised outside a result state");

endmodule

`default_nettype wire

>>> rtl/ldpc_sum_product_decoder.sv
// Top level: APB register file, stream packing and the decoder core.
`default_nettype none

// LDPC sum-product decoder, one request at a time. Append-edge, load-LLR
// and clear-edges requests are handled without leaving the idle state; a
// bit read goes through the registered memory read. After reset a clearing
// pass over the hard-decision memory holds in_tready low until it has
// covered MAX_VARS entries. A decode first counts duplicate edges if the
// edge list changed since the last decode, then seeds the messages on the
// active edges and clears the node sums over max(num_vars, num_checks)
// entries. Each iteration then makes four walks of the edge memory, plus a
// pass over the variables for the posteriors and one over the checks for
// the syndrome scan; the edge walk and its read-modify-write of the node
// memories set the pace.
module ldpc_sum_product_decoder #(
  parameter int MAX_VARS   = lspd_pkg::DEF_MAX_VARS,
  parameter int MAX_CHECKS = lspd_pkg::DEF_MAX_CHECKS,
  parameter int MAX_EDGES  = lspd_pkg::DEF_MAX_EDGES,
  parameter int LLR_WIDTH  = lspd_pkg::DEF_LLR_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // var_index, check_index, channel_llr
  input  wire logic [2:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // parity_ok, iterations_used, hard_bit, posterior_llr
  output logic [0:0]       out_tuser,  // result_kind
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  lspd_pkg::cfg_t    cfg_r, cfg_nxt;
  lspd_pkg::item_t   item;
  lspd_pkg::result_t res;
  logic              wr_req;

  assign cfg_pready = 1'b1;
  assign wr_req     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_req) begin
      case (cfg_paddr[3:2])
        lspd_pkg::REG_NUM_VARS:   cfg_nxt.num_vars   = cfg_pwdata[10:0];
        lspd_pkg::REG_NUM_CHECKS: cfg_nxt.num_checks = cfg_pwdata[9:0];
        lspd_pkg::REG_MAX_ITER:   cfg_nxt.max_iter   = cfg_pwdata[6:0];
        default: ;
      endcase
    end
    case (cfg_paddr[3:2])
      lspd_pkg::REG_NUM_VARS:   cfg_prdata = {21'd0, cfg_r.num_vars};
      lspd_pkg::REG_NUM_CHECKS: cfg_prdata = {22'd0, cfg_r.num_checks};
      lspd_pkg::REG_MAX_ITER:   cfg_prdata = {25'd0, cfg_r.max_iter};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_vars   <= lspd_pkg::RST_NUM_VARS;
      cfg_r.num_checks <= lspd_pkg::RST_NUM_CHECKS;
      cfg_r.max_iter   <= lspd_pkg::RST_MAX_ITER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign item.op          = lspd_pkg::op_t'(in_tuser);
  assign item.var_index   = in_tdata[9:0];
  assign item.check_index = in_tdata[18:10];
  assign item.channel_llr = $signed(in_tdata[26:19]);

  lspd_core #(
    .MAX_VARS(MAX_VARS), .MAX_CHECKS(MAX_CHECKS),
    .MAX_EDGES(MAX_EDGES), .LLR_WIDTH(LLR_WIDTH)
  ) u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .item(item),
    .out_valid(out_tvalid), .out_ready(out_tready), .res(res)
  );

  assign out_tuser = res.result_kind;
  assign out_tdata = {3'd0, res.posterior_llr, res.hard_bit,
                      res.iterations_used, res.parity_ok};

endmodule

`default_nettype wire
